// ----- rtl/rsip_pkg.sv -----
// ----------------------------------------------------------------------------
// rsip_pkg - shared definitions for the radix string-to-integer parser
// Character codes, base constants, register map and the digit decoder.
// ----------------------------------------------------------------------------
package rsip_pkg;

	// default length saturation point
	localparam int unsigned LENGTH_LIMIT_DEF = 255;

	// configuration register map (register index = paddr[2])
	localparam int unsigned APB_ADDR_W     = 3;
	localparam int unsigned APB_DATA_W     = 32;
	localparam logic        REG_RADIX_MODE = 1'b0;

	// character codes
	localparam logic [7:0] CH_MINUS   = 8'h2D;  // '-'
	localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
	localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
	localparam logic [7:0] CH_UPPER_A = 8'h41;  // 'A'
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;  // 'Z'
	localparam logic [7:0] CH_LOWER_A = 8'h61;  // 'a'
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;  // 'z'
	localparam logic [7:0] CH_LOWER_O = 8'h6F;  // 'o'
	localparam logic [7:0] CH_LOWER_X = 8'h78;  // 'x'
	localparam logic [7:0] CH_LOWER_B = 8'h62;  // 'b'
	localparam logic [7:0] CASE_BIT   = 8'h20;  // folds upper case onto lower

	// radix settings
	localparam logic [7:0] RADIX_AUTO = 8'd0;
	localparam logic [7:0] RADIX_MIN  = 8'd2;
	localparam logic [7:0] RADIX_MAX  = 8'd36;
	localparam logic [5:0] BASE_NONE  = 6'd0;
	localparam logic [5:0] BASE_BIN   = 6'd2;
	localparam logic [5:0] BASE_OCT   = 6'd8;
	localparam logic [5:0] BASE_DEC   = 6'd10;
	localparam logic [5:0] BASE_HEX   = 6'd16;
	localparam logic [7:0] DIGIT_NONE = 8'hFF;
	localparam logic [7:0] ALPHA_OFS  = 8'd10;

	// parse state handed from the core to the output stage
	typedef struct packed {
		logic [63:0] accum;
		logic        is_negative;
		logic        has_digits;
		logic        ended;
	} rsip_state_t;

	// digit value of a character, DIGIT_NONE when it is no digit at all
	function automatic logic [7:0] char_digit(input logic [7:0] c);
		logic [7:0] d;
		d = DIGIT_NONE;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			d = c - CH_UPPER_A + ALPHA_OFS;
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			d = c - CH_LOWER_A + ALPHA_OFS;
		end
		return d;
	endfunction

endpackage

// ----- rtl/rsip_core.sv -----
// ----------------------------------------------------------------------------
// rsip_core - parse state and per-character step logic
// Holds phase, running value, count, sign and base; one character per step
// through a single multiply-accumulate by the base.
// ----------------------------------------------------------------------------
module rsip_core
	import rsip_pkg::*;
#(
	parameter int unsigned LENGTH_LIMIT = LENGTH_LIMIT_DEF,
	parameter int unsigned CNT_W        = $clog2(LENGTH_LIMIT + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  logic [7:0]       ch,
	input  logic             first,
	input  logic [7:0]       radix_mode,
	output rsip_state_t      st,
	output logic [CNT_W-1:0] count
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_MAGSTART,
		PH_ZERO,
		PH_PREFIXED,
		PH_DIGITS,
		PH_ENDED
	} phase_t;

	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LENGTH_LIMIT);

	phase_t           phase_q, phase_d;
	logic [63:0]      accum_q, accum_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             neg_q, neg_d;
	logic [5:0]       base_q, base_d;
	logic             hd_q, hd_d;

	logic             restart;
	logic             mag_start;
	logic             take;
	logic [5:0]       take_base;
	logic [5:0]       mode_base;
	logic [63:0]      acc_in;
	logic [CNT_W-1:0] cnt_in;
	logic [CNT_W-1:0] cnt_inc;
	logic [7:0]       digit;
	logic [7:0]       ch_low;
	logic             is_prefix;
	logic [69:0]      prod;

	// base a new number uses when no prefix decides it
	always_comb begin
		if (radix_mode == RADIX_AUTO) begin
			mode_base = BASE_DEC;
		end else if (radix_mode >= RADIX_MIN && radix_mode <= RADIX_MAX) begin
			mode_base = radix_mode[5:0];
		end else begin
			mode_base = BASE_NONE;
		end
	end

	assign restart   = first || (phase_q == PH_IDLE);
	assign acc_in    = restart ? '0 : accum_q;
	assign cnt_in    = restart ? '0 : count_q;
	assign cnt_inc   = (cnt_in < CNT_LIMIT) ? cnt_in + 1'b1 : cnt_in;
	assign digit     = char_digit(ch);
	assign ch_low    = ch | CASE_BIT;
	assign is_prefix = (ch_low == CH_LOWER_O) || (ch_low == CH_LOWER_X)
	                || (ch_low == CH_LOWER_B);
	assign prod      = acc_in * take_base;

	// next state for one character
	always_comb begin
		phase_d   = phase_q;
		accum_d   = accum_q;
		count_d   = count_q;
		neg_d     = neg_q;
		base_d    = base_q;
		hd_d      = hd_q;
		mag_start = 1'b0;
		take      = 1'b0;
		take_base = base_q;

		if (restart) begin
			accum_d = '0;
			count_d = '0;
			neg_d   = 1'b0;
			base_d  = BASE_NONE;
			hd_d    = 1'b0;
			if (ch == CH_MINUS) begin
				neg_d   = 1'b1;
				phase_d = PH_MAGSTART;
			end else begin
				mag_start = 1'b1;
			end
		end else begin
			unique case (phase_q)
				PH_MAGSTART: begin
					mag_start = 1'b1;
				end
				PH_ZERO: begin
					if (is_prefix) begin
						base_d  = (ch_low == CH_LOWER_X) ? BASE_HEX :
						          (ch_low == CH_LOWER_B) ? BASE_BIN : BASE_OCT;
						count_d = cnt_inc;
						hd_d    = 1'b0;
						phase_d = PH_PREFIXED;
					end else begin
						take = 1'b1;
					end
				end
				PH_PREFIXED, PH_DIGITS: begin
					take = 1'b1;
				end
				default: begin
				end
			endcase
		end

		// first magnitude character: leading zero or base from the register
		if (mag_start) begin
			if (radix_mode == RADIX_AUTO && ch == CH_ZERO) begin
				base_d  = BASE_OCT;
				accum_d = '0;
				count_d = cnt_inc;
				hd_d    = 1'b1;
				phase_d = PH_ZERO;
			end else begin
				base_d    = mode_base;
				take      = 1'b1;
				take_base = mode_base;
			end
		end

		// digit accept: multiply-accumulate, or the number ends here
		if (take) begin
			if (take_base >= BASE_BIN && digit < {2'b00, take_base}) begin
				accum_d = prod[63:0] + {56'd0, digit};
				count_d = cnt_inc;
				hd_d    = 1'b1;
				phase_d = PH_DIGITS;
			end else begin
				phase_d = PH_ENDED;
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			accum_q <= '0;
			count_q <= '0;
			neg_q   <= 1'b0;
			base_q  <= BASE_NONE;
			hd_q    <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_d;
			accum_q <= accum_d;
			count_q <= count_d;
			neg_q   <= neg_d;
			base_q  <= base_d;
			hd_q    <= hd_d;
		end
	end

	assign st.accum       = accum_q;
	assign st.is_negative = neg_q;
	assign st.has_digits  = hd_q;
	assign st.ended       = (phase_q == PH_ENDED);
	assign count          = count_q;

endmodule

// ----- rtl/radix_string_to_int_parser_unit.sv -----
// ----------------------------------------------------------------------------
// radix_string_to_int_parser_unit - streaming string-to-integer parser
// One character per cycle when not stalled; sign and base prefix detection.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one character per request in s_tdata, s_tuser set on
//   the first character of a new string. Output stream (m_*): one result per
//   character, as if the string ended there: signed value, consumed length
//   and an ended flag.
//   APB port: radix_mode at address 0 (0 auto, 2..36 fixed base). Write it
//   only while no request is in flight.
//   Path: a request passes the input register, the parse state register
//   and the output register, in that order, before its result shows.
//   Throughput: one character per cycle when not stalled; the parse
//   core's running-value multiply-accumulate by the base sets the cycle.
//   Reset: the parse starts over and radix_mode returns to auto; a first
//   character without s_tuser after reset still starts a new string.
//   Stall: when m_tready is low the result holds; the input and state
//   registers keep taking requests until they are full, then s_tready drops.
// ----------------------------------------------------------------------------
module radix_string_to_int_parser_unit
	import rsip_pkg::*;
#(
	parameter int unsigned LENGTH_LIMIT = LENGTH_LIMIT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] ch
	input  logic                  s_tuser,   // [0] first
	// output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [71:0]           m_tdata,   // [63:0] value, [71:64] length
	output logic                  m_tuser,   // [0] ended
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int unsigned CNT_W = $clog2(LENGTH_LIMIT + 1);
	localparam logic [CNT_W:0] LEN_LIMIT = (CNT_W + 1)'(LENGTH_LIMIT);

	logic [7:0]       radix_mode_q;
	logic             cfg_wr;

	logic             s1_valid_q;
	logic [7:0]       ch_s1;
	logic             first_s1;
	logic             s2_valid_q;
	logic             m_valid_q;
	logic [63:0]      value_q;
	logic [7:0]       length_q;
	logic             ended_q;

	logic             out_rdy;
	logic             s2_adv;
	logic             s2_rdy;
	logic             s1_adv;
	logic             s_acc;

	rsip_state_t      st;
	logic [CNT_W-1:0] count;
	logic [CNT_W:0]   len_full;
	logic [CNT_W:0]   len_sat;

	// configuration register, word aligned (low address bits ignored)
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_mode_q <= RADIX_AUTO;
		end else if (cfg_wr && paddr[2] == REG_RADIX_MODE) begin
			radix_mode_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == REG_RADIX_MODE) ? {24'd0, radix_mode_q} : '0;

	// stage handshakes
	assign out_rdy  = !m_valid_q || m_tready;
	assign s2_adv   = s2_valid_q && out_rdy;
	assign s2_rdy   = !s2_valid_q || out_rdy;
	assign s1_adv   = s1_valid_q && s2_rdy;
	assign s_tready = !s1_valid_q || s2_rdy;
	assign s_acc    = s_tvalid && s_tready;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (s_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				s2_valid_q <= 1'b1;
			end else if (s2_adv) begin
				s2_valid_q <= 1'b0;
			end
			if (s2_adv) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (s_acc) begin
			ch_s1    <= s_tdata;
			first_s1 <= s_tuser;
		end
	end

	// parse state doubles as the second stage
	rsip_core #(
		.LENGTH_LIMIT (LENGTH_LIMIT),
		.CNT_W        (CNT_W)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (s1_adv),
		.ch         (ch_s1),
		.first      (first_s1),
		.radix_mode (radix_mode_q),
		.st         (st),
		.count      (count)
	);

	// length: sign counts once digits exist, saturating
	assign len_full = {1'b0, count} + {{CNT_W{1'b0}}, st.is_negative};
	assign len_sat  = (len_full > LEN_LIMIT) ? LEN_LIMIT : len_full;

	// output register: apply sign and length
	always_ff @(posedge clk) begin
		if (s2_adv) begin
			value_q  <= st.is_negative ? (64'd0 - st.accum) : st.accum;
			length_q <= st.has_digits ? 8'(len_sat) : 8'd0;
			ended_q  <= st.ended;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {length_q, value_q};
	assign m_tuser  = ended_q;

	// no digits accepted means the running value is still zero
	a_nodigit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!st.has_digits |-> st.accum == 64'd0)
		else $error("running value nonzero without digits");

	// count never passes the saturation point
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, count} <= LEN_LIMIT)
		else $error("digit count above limit");

	// an ended number stays ended until a new string starts
	a_ended_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(st.ended && s1_adv && !first_s1) |=> st.ended)
		else $error("ended flag cleared within a string");

	// a held input item is not overwritten
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s2_rdy) |=> (s1_valid_q && $stable(ch_s1) && $stable(first_s1)))
		else $error("input register overwritten while stalled");

endmodule
